// ----- src/wildcard_star_regex_matcher_macros.svh -----
// Assertion macros for the matcher RTL.
`ifndef WILDCARD_STAR_REGEX_MATCHER_MACROS_SVH
`define WILDCARD_STAR_REGEX_MATCHER_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define WSRM_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("matcher assertion failed");

// Next-cycle implication, checked out of reset.
`define WSRM_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("matcher assertion failed");

`endif

// ----- src/wsrm_pkg.sv -----
// Shared types and constants of the wildcard/star matcher.
package wsrm_pkg;

    localparam int PATTERN_DEPTH_DEF = 16;

    localparam logic [7:0] SYM_STAR = 8'd42;
    localparam logic [7:0] SYM_DOT  = 8'd46;

    typedef enum logic [1:0] {
        OP_CLEAR  = 2'd0,
        OP_APPEND = 2'd1,
        OP_BEGIN  = 2'd2,
        OP_TEXT   = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_START,
        ST_SWEEP,
        ST_EMIT
    } state_t;

endpackage

// ----- src/wsrm_in_if.sv -----
// Input channel: operation and symbol with valid/ready.
interface wsrm_in_if;
    import wsrm_pkg::*;

    logic       valid;
    logic       ready;
    op_t        operation;
    logic [7:0] symbol;

    modport source (output valid, output operation, output symbol, input ready);
    modport sink   (input valid, input operation, input symbol, output ready);
endinterface

// ----- src/wsrm_out_if.sv -----
// Result channel: match bit and overflow flag with valid/ready.
interface wsrm_out_if;
    logic valid;
    logic ready;
    logic matched;
    logic pattern_overflow;

    modport source (output valid, output matched, output pattern_overflow, input ready);
    modport sink   (input valid, input matched, input pattern_overflow, output ready);
endinterface

// ----- src/wsrm_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module wsrm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

// ----- src/wildcard_star_regex_matcher.sv -----
// Top level of the wildcard/star whole-text matcher.
// The pattern ('.' matches any byte, '*' repeats the element before it) is
// loaded one byte per transfer into a RAM of PATTERN_DEPTH bytes; a byte past
// capacity is dropped and sets the sticky pattern_overflow flag, which only a
// clear-pattern operation resets. One dynamic-programming row, one bit per
// pattern prefix, is held in registers. Every operation rebuilds or advances
// that row by sweeping the pattern RAM through its single read port, one
// pattern byte per cycle: an item passes through accept, read launch and one
// sweep step per stored pattern byte, and begin-text and text-byte operations
// then load the result register, waiting while the output slot is full, so
// the rate is set by the pattern length and that one read port.
// The input side takes a new transfer while a result still waits on the
// output side. Clear and append give no result; begin and text give one.
// A leading '*' has no element to repeat, so its prefix never matches.
`include "wildcard_star_regex_matcher_macros.svh"

module wildcard_star_regex_matcher #(
    parameter int PATTERN_DEPTH = wsrm_pkg::PATTERN_DEPTH_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    wsrm_in_if.sink    items,
    wsrm_out_if.source results
);
    import wsrm_pkg::*;

    localparam int LEN_W  = $clog2(PATTERN_DEPTH + 1);
    localparam int ADDR_W = $clog2(PATTERN_DEPTH);
    localparam logic [LEN_W-1:0] DEPTH_L = LEN_W'(PATTERN_DEPTH);
    localparam logic [LEN_W-1:0] ONE_L   = LEN_W'(1);

    // Control state
    state_t                 state_reg, state_next;
    logic [LEN_W-1:0]       len_reg;
    logic [LEN_W-1:0]       j_reg;
    logic                   flag_reg;
    logic [PATTERN_DEPTH:0] row_reg;
    logic                   out_valid_reg;

    // Item payload and sweep carries
    op_t        op_reg;
    logic [7:0] sym_reg;
    logic [7:0] prev_reg;      // pattern byte j-2
    logic       n1_reg;        // new row bit j-1
    logic       n2_reg;        // new row bit j-2
    logic       old_prev_reg;  // old row bit j-1
    logic       matched_reg;
    logic       ovf_reg;

    // RAM ports
    logic              ram_we;
    logic [ADDR_W-1:0] ram_waddr;
    logic [ADDR_W-1:0] ram_raddr;
    logic [7:0]        ram_rdata;

    logic accept;
    logic has_result;
    logic out_free;
    logic start_mode;
    logic not_first;
    logic old_j;
    logic new_bit;

    wsrm_ram #(
        .WIDTH(8),
        .DEPTH(PATTERN_DEPTH)
    ) u_pattern_ram (
        .clk  (clk),
        .we   (ram_we),
        .waddr(ram_waddr),
        .wdata(items.symbol),
        .raddr(ram_raddr),
        .rdata(ram_rdata)
    );

    assign accept     = items.valid && items.ready;
    assign has_result = op_reg inside {OP_BEGIN, OP_TEXT};
    assign out_free   = !out_valid_reg || results.ready;
    // Clear, append and begin all rebuild the empty-text row.
    assign start_mode = (op_reg != OP_TEXT);
    assign not_first  = (j_reg != ONE_L);
    assign old_j      = row_reg[j_reg];

    // One DP cell: row bit j from pattern byte j-1 (RAM data) and the carries.
    always_comb
    begin
        new_bit = 1'b0;
        if (start_mode)
        begin
            new_bit = (ram_rdata == SYM_STAR) && not_first && n2_reg;
        end
        else if (ram_rdata == SYM_STAR)
        begin
            new_bit = not_first &&
                      (n2_reg || n1_reg ||
                       (old_j && (prev_reg == SYM_DOT || prev_reg == sym_reg)));
        end
        else if (ram_rdata == SYM_DOT)
        begin
            new_bit = old_prev_reg;
        end
        else
        begin
            new_bit = old_prev_reg && (ram_rdata == sym_reg);
        end
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_START;
                end
            end
            ST_START:
            begin
                if (len_reg != '0)
                begin
                    state_next = ST_SWEEP;
                end
                else
                begin
                    state_next = has_result ? ST_EMIT : ST_IDLE;
                end
            end
            ST_SWEEP:
            begin
                if (j_reg == len_reg)
                begin
                    state_next = has_result ? ST_EMIT : ST_IDLE;
                end
            end
            ST_EMIT:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Outputs of the sequencer
    always_comb
    begin
        items.ready = 1'b0;
        ram_raddr   = '0;
        ram_we      = 1'b0;
        ram_waddr   = len_reg[ADDR_W-1:0];
        case (state_reg)
            ST_IDLE:
            begin
                items.ready = 1'b1;
                ram_we      = accept && (items.operation == OP_APPEND) &&
                              (len_reg < DEPTH_L);
            end
            ST_START:
            begin
                ram_raddr = '0;
            end
            ST_SWEEP:
            begin
                // launch the read of the next pattern byte
                ram_raddr = j_reg[ADDR_W-1:0];
            end
            ST_EMIT:
            begin
                ram_raddr = '0;
            end
            default:
            begin
                ram_raddr = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            len_reg       <= '0;
            j_reg         <= ONE_L;
            flag_reg      <= 1'b0;
            row_reg       <= {{PATTERN_DEPTH{1'b0}}, 1'b1};
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            // Load a new result when the slot frees; otherwise drop a taken one.
            if (state_reg == ST_EMIT && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (results.ready)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        if (items.operation == OP_CLEAR)
                        begin
                            len_reg  <= '0;
                            flag_reg <= 1'b0;
                        end
                        else if (items.operation == OP_APPEND)
                        begin
                            if (len_reg < DEPTH_L)
                            begin
                                len_reg <= len_reg + ONE_L;
                            end
                            else
                            begin
                                flag_reg <= 1'b1;
                            end
                        end
                    end
                end
                ST_START:
                begin
                    row_reg[0] <= start_mode;
                    j_reg      <= ONE_L;
                end
                ST_SWEEP:
                begin
                    row_reg[j_reg] <= new_bit;
                    j_reg          <= j_reg + ONE_L;
                end
                default:
                begin
                    j_reg <= ONE_L;
                end
            endcase
        end
    end

    // Payload and sweep carries: no reset needed
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg  <= items.operation;
            sym_reg <= items.symbol;
        end
        if (state_reg == ST_START)
        begin
            n1_reg       <= start_mode;
            old_prev_reg <= row_reg[0];
        end
        if (state_reg == ST_SWEEP)
        begin
            n2_reg       <= n1_reg;
            n1_reg       <= new_bit;
            old_prev_reg <= old_j;
            prev_reg     <= ram_rdata;
        end
        if (state_reg == ST_EMIT && out_free)
        begin
            matched_reg <= row_reg[len_reg];
            ovf_reg     <= flag_reg;
        end
    end

    assign results.valid            = out_valid_reg;
    assign results.matched          = matched_reg;
    assign results.pattern_overflow = ovf_reg;

    // Assertions
    `WSRM_ASSERT_NOW(a_len_bound, 1'b1, len_reg <= DEPTH_L)
    `WSRM_ASSERT_NOW(a_sweep_range, state_reg == ST_SWEEP, j_reg >= ONE_L && j_reg <= len_reg)
    `WSRM_ASSERT_NOW(a_emit_has_result, state_reg == ST_EMIT, op_reg == OP_BEGIN || op_reg == OP_TEXT)
    `WSRM_ASSERT_NOW(a_flag_rise, $rose(flag_reg), $past(accept) && $past(items.operation) == OP_APPEND)

endmodule

// ----- bench/wsrm_match_checker.sv -----
// Watches both matcher channels, predicts each result and compares it.
module wsrm_match_checker #(
    parameter int PATTERN_DEPTH = wsrm_pkg::PATTERN_DEPTH_DEF
) (
    input  logic clk,
    input  logic rst_n,
    wsrm_in_if   items,
    wsrm_out_if  results,
    output int   failures,
    output int   outstanding
);
    timeunit 1ns;
    timeprecision 1ps;
    import wsrm_pkg::*;

    typedef struct packed {
        logic matched;
        logic pattern_overflow;
    } verdict_t;

    logic [7:0]           pat_bytes [PATTERN_DEPTH];
    int                   pat_len;
    logic [PATTERN_DEPTH:0] prefix_hits;
    logic                 overflow_seen;
    verdict_t             verdicts_due [$];
    int                   mismatch_tally = 0;

    assign failures = mismatch_tally;

    // Row for the empty text under the current pattern.
    function automatic void restart_row();
        prefix_hits    = '0;
        prefix_hits[0] = 1'b1;
        for (int j = 1; j <= pat_len; j++) begin
            if (pat_bytes[j-1] == SYM_STAR && j >= 2)
                prefix_hits[j] = prefix_hits[j-2];
        end
    endfunction

    // Advance the row by one text byte.
    function automatic void consume_byte(logic [7:0] c);
        logic [PATTERN_DEPTH:0] nxt;
        logic [7:0]             p;
        logic [7:0]             prev;
        nxt = '0;
        for (int j = 1; j <= pat_len; j++) begin
            p = pat_bytes[j-1];
            if (p == SYM_STAR) begin
                if (j >= 2) begin
                    prev   = pat_bytes[j-2];
                    nxt[j] = nxt[j-2] | nxt[j-1]
                           | (prefix_hits[j] & (prev == SYM_DOT || prev == c));
                end
            end else if (p == SYM_DOT) begin
                nxt[j] = prefix_hits[j-1];
            end else begin
                nxt[j] = prefix_hits[j-1] & (p == c);
            end
        end
        prefix_hits = nxt;
    endfunction

    always @(posedge clk or negedge rst_n) begin : watch
        verdict_t due;
        if (!rst_n) begin
            foreach (pat_bytes[i]) pat_bytes[i] = 8'h00;
            pat_len       = 0;
            overflow_seen = 1'b0;
            restart_row();
            verdicts_due.delete();
            outstanding <= 0;
        end else begin
            if (items.valid && items.ready) begin
                case (items.operation)
                    OP_CLEAR: begin
                        pat_len       = 0;
                        overflow_seen = 1'b0;
                        restart_row();
                    end
                    OP_APPEND: begin
                        if (pat_len < PATTERN_DEPTH) begin
                            pat_bytes[pat_len] = items.symbol;
                            pat_len++;
                        end else begin
                            overflow_seen = 1'b1;
                        end
                        restart_row();
                    end
                    OP_BEGIN: begin
                        restart_row();
                        verdicts_due.push_back({prefix_hits[pat_len], overflow_seen});
                    end
                    default: begin
                        consume_byte(items.symbol);
                        verdicts_due.push_back({prefix_hits[pat_len], overflow_seen});
                    end
                endcase
            end
            if (results.valid && results.ready) begin
                if (verdicts_due.size() == 0) begin
                    $error("unexpected result: matched %0b pattern_overflow %0b",
                           results.matched, results.pattern_overflow);
                    mismatch_tally++;
                end else begin
                    due = verdicts_due.pop_front();
                    if (results.matched !== due.matched) begin
                        $error("matched: expected %0b, got %0b",
                               due.matched, results.matched);
                        mismatch_tally++;
                    end
                    if (results.pattern_overflow !== due.pattern_overflow) begin
                        $error("pattern_overflow: expected %0b, got %0b",
                               due.pattern_overflow, results.pattern_overflow);
                        mismatch_tally++;
                    end
                end
            end
            outstanding <= verdicts_due.size();
        end
    end

endmodule

// ----- bench/wildcard_star_regex_matcher_test.sv -----
// Stimulus, reset, watchdog and verdict for the wildcard/star matcher.
module wildcard_star_regex_matcher_test;
    timeunit 1ns;
    timeprecision 1ps;
    import wsrm_pkg::*;

    // Stop once this many items have gone in; the last stretch runs calm.
    localparam int ITEM_TARGET  = 1150;
    localparam int CALM_FROM    = 1000;
    // A correct block never goes this long without a transfer on either side,
    // even with a full pattern sweep, a sender gap and a receiver stall.
    localparam int STALL_LIMIT  = 2000;
    // Cycles to linger after the last result.
    localparam int DRAIN_CYCLES = 4 * PATTERN_DEPTH_DEF;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    wsrm_in_if  items_ch ();
    wsrm_out_if results_ch ();

    int failures;
    int outstanding;

    wildcard_star_regex_matcher u_top (
        .clk     (clk),
        .rst_n   (rst_n),
        .items   (items_ch),
        .results (results_ch)
    );

    wsrm_match_checker u_check (
        .clk         (clk),
        .rst_n       (rst_n),
        .items       (items_ch),
        .results     (results_ch),
        .failures    (failures),
        .outstanding (outstanding)
    );

    always #1 clk = ~clk;

    // Stimulus-side picture of what the pattern store holds, so that texts
    // can be built that actually walk the pattern instead of dying at once.
    logic [7:0] loaded [$];
    int         sent       = 0;
    bit         calm       = 1'b0;
    // Idle odds: 0 means no idling, N means one chance in N+1 per item/cycle.
    int         send_odds  = 0;
    int         sink_odds  = 3;
    int         stall_left = 0;
    int         quiet_cycles = 0;

    // Receiver: hold ready low in random bursts, re-pick the burst odds now
    // and then so some stretches never stall.
    always @(negedge clk) begin
        if ($urandom_range(0, 63) == 0) begin
            case ($urandom_range(0, 3))
                0:       sink_odds = 0;
                1:       sink_odds = 1;
                2:       sink_odds = 4;
                default: sink_odds = 12;
            endcase
        end
        if (calm) begin
            results_ch.ready <= 1'b1;
        end else if (stall_left > 0) begin
            stall_left--;
            results_ch.ready <= 1'b0;
        end else if (sink_odds != 0 && $urandom_range(0, sink_odds) == 0) begin
            stall_left = $urandom_range(0, 15);
            results_ch.ready <= 1'b0;
        end else begin
            results_ch.ready <= 1'b1;
        end
    end

    // Watchdog: count cycles without any transfer; give up at the limit.
    always @(posedge clk) begin
        if ((items_ch.valid && items_ch.ready) || (results_ch.valid && results_ch.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    // Pattern bytes come mostly from a tiny alphabet so matches happen often.
    function automatic logic [7:0] narrow_byte(bit specials);
        case ($urandom_range(0, specials ? 5 : 1))
            0:       return "a";
            1:       return "b";
            2, 3:    return SYM_STAR;
            default: return SYM_DOT;
        endcase
    endfunction

    // Drive one item, called at a falling edge; return at the falling edge
    // after its transfer. Valid stays high so back-to-back items need no
    // second assignment in the same step; it only drops for an idle burst.
    task automatic send_item(input op_t op, input logic [7:0] sym);
        int gap;
        if (!calm && send_odds != 0 && $urandom_range(0, send_odds) == 0) begin
            items_ch.valid <= 1'b0;
            gap = $urandom_range(1, 16);
            repeat (gap) @(negedge clk);
        end
        items_ch.operation <= op;
        items_ch.symbol    <= sym;
        items_ch.valid     <= 1'b1;
        @(posedge clk);
        while (!items_ch.ready) @(posedge clk);
        @(negedge clk);
        // Track the store the same way the block does: drop bytes past capacity.
        if (op == OP_CLEAR)
            loaded.delete();
        else if (op == OP_APPEND && loaded.size() < PATTERN_DEPTH_DEF)
            loaded.push_back(sym);
        sent++;
        if (sent >= CALM_FROM)
            calm = 1'b1;
    endtask

    // One pattern followed by a few texts. Most texts are built to follow
    // the pattern element by element; the rest are random, and a few items
    // of random noise land in the middle of a text.
    task automatic run_sequence();
        int         plen;
        int         texts;
        int         tlen;
        int         reps;
        int         r;
        int         i;
        bit         wide;
        logic [7:0] sym;
        logic [7:0] txt [$];
        case ($urandom_range(0, 3))
            0:       send_odds = 0;
            1:       send_odds = 2;
            2:       send_odds = 5;
            default: send_odds = 11;
        endcase
        // Sometimes skip the clear so new bytes extend the old pattern.
        if ($urandom_range(0, 5) != 0)
            send_item(OP_CLEAR, 8'($urandom));
        r    = $urandom_range(0, 9);
        plen = (r == 0) ? $urandom_range(13, 20) : (r == 1) ? 0 : $urandom_range(1, 6);
        wide = ($urandom_range(0, 4) == 0);
        repeat (plen) begin
            sym = wide ? 8'($urandom) : narrow_byte(1'b1);
            send_item(OP_APPEND, sym);
        end
        texts = $urandom_range(1, 4);
        repeat (texts) begin
            txt.delete();
            if ($urandom_range(0, 4) < 3) begin
                i = 0;
                while (i < loaded.size()) begin
                    if (loaded[i] == SYM_STAR) begin
                        // Leading star, or a star repeating a star: take zero copies.
                        i++;
                    end else if (i + 1 < loaded.size() && loaded[i+1] == SYM_STAR) begin
                        reps = $urandom_range(0, 3);
                        repeat (reps)
                            txt.push_back(loaded[i] == SYM_DOT ? narrow_byte(1'b0) : loaded[i]);
                        i += 2;
                    end else begin
                        txt.push_back(loaded[i] == SYM_DOT ? narrow_byte(1'b0) : loaded[i]);
                        i++;
                    end
                end
                // Spoil some of them with a trailing byte.
                if ($urandom_range(0, 3) == 0)
                    txt.push_back(narrow_byte(1'b0));
            end else begin
                tlen = $urandom_range(0, 8);
                repeat (tlen) txt.push_back(wide ? 8'($urandom) : narrow_byte(1'b0));
            end
            send_item(OP_BEGIN, 8'($urandom));
            foreach (txt[k]) begin
                if ($urandom_range(0, 24) == 0)
                    send_item(op_t'($urandom_range(0, 3)), 8'($urandom));
                send_item(OP_TEXT, txt[k]);
            end
        end
    endtask

    initial begin
        items_ch.valid     = 1'b0;
        items_ch.operation = OP_CLEAR;
        items_ch.symbol    = 8'h00;
        results_ch.ready   = 1'b0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Empty pattern: only the empty text matches.
        send_item(OP_BEGIN, 8'h00);
        send_item(OP_TEXT, 8'h00);
        // "a*" matches the empty text and runs of a.
        send_item(OP_CLEAR, 8'hFF);
        send_item(OP_APPEND, "a");
        send_item(OP_APPEND, SYM_STAR);
        send_item(OP_BEGIN, 8'hFF);
        send_item(OP_TEXT, "a");
        send_item(OP_TEXT, "a");
        send_item(OP_TEXT, "b");
        // Change the pattern mid-text: the row restarts as for an empty text.
        send_item(OP_APPEND, SYM_DOT);
        send_item(OP_TEXT, 8'hFF);
        // Leading star before a literal: the pattern never matches.
        send_item(OP_CLEAR, 8'h00);
        send_item(OP_APPEND, SYM_STAR);
        send_item(OP_APPEND, "a");
        send_item(OP_BEGIN, 8'h00);
        send_item(OP_TEXT, "a");
        // Star after star repeats a literal star byte.
        send_item(OP_CLEAR, 8'h00);
        send_item(OP_APPEND, SYM_DOT);
        send_item(OP_APPEND, SYM_STAR);
        send_item(OP_APPEND, SYM_STAR);
        send_item(OP_BEGIN, 8'h00);
        send_item(OP_TEXT, SYM_STAR);
        send_item(OP_TEXT, 8'h00);
        send_item(OP_APPEND, 8'hFF);
        send_item(OP_TEXT, 8'hFF);

        // Fill the store past capacity to raise the sticky overflow flag,
        // then let the random part clear it again.
        send_item(OP_CLEAR, 8'h00);
        repeat (PATTERN_DEPTH_DEF + 2) send_item(OP_APPEND, narrow_byte(1'b1));
        send_item(OP_BEGIN, 8'h00);

        while (sent < ITEM_TARGET)
            run_sequence();

        // Drop valid, wait for every expected result, then linger a while.
        items_ch.valid <= 1'b0;
        while (outstanding != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (failures == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

// ----- sim.f -----
+incdir+src
src/wsrm_pkg.sv
src/wsrm_in_if.sv
src/wsrm_out_if.sv
src/wsrm_ram.sv
src/wildcard_star_regex_matcher.sv
bench/wsrm_match_checker.sv
bench/wildcard_star_regex_matcher_test.sv
